### rtl/core/wbs_pkg.sv
// ----------------------------------------------------------------------------
// wbs_pkg
// Shared types and codes for the word-break segmenter: beat payloads,
// item kinds and the dictionary control group.
// ----------------------------------------------------------------------------
package wbs_pkg;

    localparam int CHAR_W = 8;

    localparam logic [1:0] KIND_DICT  = 2'd0;
    localparam logic [1:0] KIND_TEXT  = 2'd1;
    localparam logic [1:0] KIND_EOT   = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CHAR_W-1:0] char_code;
        logic              word_end;
    } in_t;

    typedef struct packed {
        logic segmentable;
        logic words_dropped;
    } out_t;

    typedef struct packed {
        logic load;
        logic last;
        logic clear;
    } dict_ctrl_t;

endpackage

### rtl/core/word_break_segmenter_core.sv
// ----------------------------------------------------------------------------
// word_break_segmenter_core
// Streaming word-break check of a text against a loaded dictionary.
// ----------------------------------------------------------------------------
// Dictionary, end-of-text and clear beats are taken straight from idle.
// A text character starts a scan: the scan reads one stored word per cycle
// from the dictionary memory's single read port and checks it against the row
// of window cells, whose reachability bits shift once the last word is checked.
// Input is not taken while a scan runs or while an end-of-text result waits to
// be taken.
// ----------------------------------------------------------------------------
module word_break_segmenter_core #(
    parameter int MAX_WORDS    = 16,
    parameter int MAX_WORD_LEN = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  wbs_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output wbs_pkg::out_t out_data
);
    import wbs_pkg::*;

    localparam int LENW = $clog2(MAX_WORD_LEN + 1);
    localparam int CW   = $clog2(MAX_WORDS + 1);
    localparam int AW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int L    = MAX_WORD_LEN;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic          state_reg;
    logic          state_next;
    logic [CW-1:0] scan_addr_reg;
    logic [CW-1:0] scan_addr_next;
    logic          rd_pend_reg;
    logic          rd_pend_next;
    logic          hit_reg;
    logic          hit_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    out_t          out_data_reg;
    out_t          out_data_next;

    logic          accept;
    logic          text_shift;
    logic          restart;
    logic          issue;
    logic          scan_done;
    logic          hit_final;
    dict_ctrl_t    dict_ctrl;

    logic [L-1:0][CHAR_W-1:0] text_in;
    logic [L-1:0][CHAR_W-1:0] text_q;
    logic [L-1:0][CHAR_W-1:0] dict_in;
    logic [L-1:0][CHAR_W-1:0] dict_q;
    logic [L-1:0][CHAR_W-1:0] cmp_chars;
    logic [L-1:0]             seen_in;
    logic [L-1:0]             seen_q;
    logic [L-1:0]             reach_in;
    logic [L-1:0]             reach_q;
    logic [L:0]               ok_c;
    logic [L:0]               hit_c;
    logic [LENW-1:0]          rd_len;
    logic [CW-1:0]            word_count;
    logic                     dropped;

    assign in_ready   = (state_reg == ST_IDLE) & (~out_valid_reg | out_ready);
    assign accept     = in_valid & in_ready;
    assign text_shift = accept & (in_data.kind == KIND_TEXT);
    assign restart    = accept & (in_data.kind == KIND_EOT);

    assign dict_ctrl.load  = accept & (in_data.kind == KIND_DICT);
    assign dict_ctrl.last  = in_data.word_end;
    assign dict_ctrl.clear = accept & (in_data.kind == KIND_CLEAR);

    assign issue     = (state_reg == ST_SCAN) & (scan_addr_reg < word_count);
    assign hit_final = hit_reg | (rd_pend_reg & ok_c[L] & hit_c[L]);
    assign scan_done = (state_reg == ST_SCAN) & ~issue;

    always_comb
    begin
        state_next     = state_reg;
        scan_addr_next = scan_addr_reg;
        rd_pend_next   = 1'b0;
        hit_next       = hit_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (text_shift)
                begin
                    state_next     = ST_SCAN;
                    scan_addr_next = '0;
                    hit_next       = 1'b0;
                end
            end
            ST_SCAN:
            begin
                rd_pend_next = issue;
                hit_next     = hit_final;
                if (issue)
                begin
                    scan_addr_next = scan_addr_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (restart)
        begin
            out_valid_next              = 1'b1;
            out_data_next.segmentable   = reach_q[0];
            out_data_next.words_dropped = dropped;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_addr_reg <= '0;
            rd_pend_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_addr_reg <= scan_addr_next;
            rd_pend_reg   <= rd_pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign ok_c[0]  = 1'b1;
    assign hit_c[0] = 1'b0;

    // newest character enters at cell zero
    always_comb
    begin
        for (int j = 0; j < L; j++)
        begin
            if (j == 0)
            begin
                text_in[j]  = in_data.char_code;
                dict_in[j]  = in_data.char_code;
                seen_in[j]  = 1'b1;
                reach_in[j] = hit_final;
            end
            else
            begin
                text_in[j]  = text_q[j-1];
                dict_in[j]  = dict_q[j-1];
                seen_in[j]  = seen_q[j-1];
                reach_in[j] = reach_q[j-1];
            end
        end
    end

    wbs_dict #(
        .MAX_WORDS    (MAX_WORDS),
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .LENW         (LENW),
        .CW           (CW),
        .AW           (AW)
    ) u_dict (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (dict_ctrl),
        .wr_chars   (dict_in),
        .rd_en      (issue),
        .rd_addr    (scan_addr_reg[AW-1:0]),
        .rd_len     (rd_len),
        .rd_chars   (cmp_chars),
        .word_count (word_count),
        .dropped    (dropped)
    );

    for (genvar g = 0; g < L; g++)
    begin : g_cell
        wbs_cell #(
            .IDX  (g),
            .LENW (LENW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .text_shift  (text_shift),
            .restart     (restart),
            .text_in     (text_in[g]),
            .text_out    (text_q[g]),
            .seen_in     (seen_in[g]),
            .seen_out    (seen_q[g]),
            .dict_shift  (dict_ctrl.load),
            .dict_in     (dict_in[g]),
            .dict_out    (dict_q[g]),
            .reach_shift (scan_done),
            .reach_in    (reach_in[g]),
            .reach_out   (reach_q[g]),
            .cmp_char    (cmp_chars[g]),
            .cmp_len     (rd_len),
            .ok_in       (ok_c[g]),
            .ok_out      (ok_c[g+1]),
            .hit_in      (hit_c[g]),
            .hit_out     (hit_c[g+1])
        );
    end

endmodule

### rtl/core/wbs_cell.sv
// ----------------------------------------------------------------------------
// wbs_cell
// One window position: holds a text character, a dictionary staging
// character, a reachability bit and a filled bit, and takes part in the
// match chain against the dictionary row under comparison.
// ----------------------------------------------------------------------------
module wbs_cell #(
    parameter int IDX  = 0,
    parameter int LENW = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       text_shift,
    input  logic                       restart,
    input  logic [wbs_pkg::CHAR_W-1:0] text_in,
    output logic [wbs_pkg::CHAR_W-1:0] text_out,
    input  logic                       seen_in,
    output logic                       seen_out,
    input  logic                       dict_shift,
    input  logic [wbs_pkg::CHAR_W-1:0] dict_in,
    output logic [wbs_pkg::CHAR_W-1:0] dict_out,
    input  logic                       reach_shift,
    input  logic                       reach_in,
    output logic                       reach_out,
    input  logic [wbs_pkg::CHAR_W-1:0] cmp_char,
    input  logic [LENW-1:0]            cmp_len,
    input  logic                       ok_in,
    output logic                       ok_out,
    input  logic                       hit_in,
    output logic                       hit_out
);
    import wbs_pkg::*;

    localparam logic REACH_INIT = (IDX == 0);

    logic [CHAR_W-1:0] text_reg;
    logic [CHAR_W-1:0] dict_reg;
    logic              reach_reg;
    logic              seen_reg;
    logic              active;
    logic              tail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reach_reg <= REACH_INIT;
            seen_reg  <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                reach_reg <= REACH_INIT;
                seen_reg  <= 1'b0;
            end
            else
            begin
                if (reach_shift)
                begin
                    reach_reg <= reach_in;
                end
                if (text_shift)
                begin
                    seen_reg <= seen_in;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_shift)
        begin
            text_reg <= text_in;
        end
        if (dict_shift)
        begin
            dict_reg <= dict_in;
        end
    end

    // position inside the word, and the position holding its first char
    assign active = LENW'(IDX) < cmp_len;
    assign tail   = cmp_len == LENW'(IDX + 1);

    assign ok_out    = ok_in & (~active | (cmp_char == text_reg));
    assign hit_out   = hit_in | (tail & reach_reg & seen_reg);
    assign text_out  = text_reg;
    assign dict_out  = dict_reg;
    assign seen_out  = seen_reg;
    assign reach_out = reach_reg;

endmodule

### rtl/core/wbs_dict.sv
// ----------------------------------------------------------------------------
// wbs_dict
// Dictionary store: word loader with fill and word counters, the dropped
// flag, and a row memory holding each word's length and its characters
// newest-first, read one row per cycle.
// ----------------------------------------------------------------------------
module wbs_dict #(
    parameter int MAX_WORDS    = 16,
    parameter int MAX_WORD_LEN = 16,
    parameter int LENW         = 5,
    parameter int CW           = 5,
    parameter int AW           = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wbs_pkg::dict_ctrl_t                  ctrl,
    input  logic [MAX_WORD_LEN*wbs_pkg::CHAR_W-1:0] wr_chars,
    input  logic                                 rd_en,
    input  logic [AW-1:0]                        rd_addr,
    output logic [LENW-1:0]                      rd_len,
    output logic [MAX_WORD_LEN*wbs_pkg::CHAR_W-1:0] rd_chars,
    output logic [CW-1:0]                        word_count,
    output logic                                 dropped
);
    import wbs_pkg::*;

    localparam int FW   = $clog2(MAX_WORD_LEN + 2);
    localparam int ROWW = LENW + MAX_WORD_LEN * CHAR_W;

    logic [ROWW-1:0] mem [MAX_WORDS];
    logic [ROWW-1:0] rd_data_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic          dropped_reg;
    logic          dropped_next;
    logic [FW-1:0] fill_inc;
    logic          reject;
    logic          wr_en;

    assign fill_inc = (fill_reg <= FW'(MAX_WORD_LEN)) ? fill_reg + FW'(1) : fill_reg;
    assign reject   = (fill_inc > FW'(MAX_WORD_LEN)) || (count_reg >= CW'(MAX_WORDS));
    assign wr_en    = ctrl.load & ctrl.last & ~reject;

    always_comb
    begin
        count_next   = count_reg;
        fill_next    = fill_reg;
        dropped_next = dropped_reg;
        priority if (ctrl.clear)
        begin
            count_next   = '0;
            fill_next    = '0;
            dropped_next = 1'b0;
        end
        else if (ctrl.load)
        begin
            if (ctrl.last)
            begin
                fill_next = '0;
                if (reject)
                begin
                    dropped_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            else
            begin
                fill_next = fill_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            fill_reg    <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            fill_reg    <= fill_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= {fill_inc[LENW-1:0], wr_chars};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_len     = rd_data_reg[ROWW-1 -: LENW];
    assign rd_chars   = rd_data_reg[MAX_WORD_LEN*CHAR_W-1:0];
    assign word_count = count_reg;
    assign dropped    = dropped_reg;

endmodule

### rtl/core/wbs_checker.sv
// ----------------------------------------------------------------------------
// wbs_checker
// Port-level checks for the word-break segmenter, bound to the top level.
// ----------------------------------------------------------------------------
module wbs_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input wbs_pkg::in_t  in_data,
    input logic          out_valid,
    input logic          out_ready,
    input wbs_pkg::out_t out_data
);
    import wbs_pkg::*;

    // a waiting result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // no input while a result is stuck
    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

    // end of text always yields a result next cycle
    a_eot_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.kind == KIND_EOT |=> out_valid)
        else $error("end of text gave no result");

    // text character starts a scan that blocks input
    a_text_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.kind == KIND_TEXT |=> !in_ready)
        else $error("input taken during scan");

    // other beats create no result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.kind != KIND_EOT && !out_valid |=> !out_valid)
        else $error("unexpected result beat");

endmodule

bind word_break_segmenter_core wbs_checker u_wbs_checker (.*);

### tb/word_break_segmenter_core_test.sv
// ----------------------------------------------------------------------------
// word_break_segmenter_core_test
// Self-checking bench for the word-break segmenter. Dictionary and text beats
// go in over a valid/ready channel. A cycle-free predictor computes the verdict
// for each end-of-text beat, and a checker compares each result beat with
// the oldest pending verdict. Directed cases run first, then dropped-word cases,
// then random word-built texts, held results, then more under idle and stall mixes.
// ----------------------------------------------------------------------------
module word_break_segmenter_core_test;

    import wbs_pkg::*;

    localparam int N_WORDS     = 16;
    localparam int WORD_MAX    = 16;
    localparam int STUCK_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int PRINT_CAP   = 20;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    // predictor state
    logic [7:0]        lex_chars [N_WORDS][WORD_MAX];
    int                lex_len [N_WORDS];
    int                lex_count;
    int                lex_fill;
    logic              lex_dropped;
    logic [7:0]        recent_chars [WORD_MAX];
    logic [WORD_MAX:0] reachable;
    int                text_seen;
    out_t              pending_verdicts [$];

    // stimulus and bookkeeping
    logic [7:0] glyphs [4];
    int         glyph_n;
    int         send_idle_pct;
    int         stall_pct;
    int         hold_left;
    int         beats_sent;
    int         verdicts_seen;
    int         seg_true_seen;
    int         dropped_seen;
    int         mismatch_count;
    int         stuck_cycles;
    out_t       verdict_due;

    word_break_segmenter_core #(
        .MAX_WORDS    (N_WORDS),
        .MAX_WORD_LEN (WORD_MAX)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic restart_text();
        int i;
        for (i = 0; i < WORD_MAX; i++)
            recent_chars[i] = 8'h00;
        reachable = (WORD_MAX + 1)'(1);
        text_seen = 0;
    endtask

    task automatic reset_segmenter();
        int w;
        int i;
        for (w = 0; w < N_WORDS; w++)
        begin
            lex_len[w] = 0;
            for (i = 0; i < WORD_MAX; i++)
                lex_chars[w][i] = 8'h00;
        end
        lex_count   = 0;
        lex_fill    = 0;
        lex_dropped = 1'b0;
        restart_text();
    endtask

    function automatic bit word_ends_here(int w);
        int len;
        int i;
        len = lex_len[w];
        if (len == 0 || len > WORD_MAX || len > text_seen)
            return 1'b0;
        if (!reachable[len-1])
            return 1'b0;
        for (i = 0; i < len; i++)
            if (lex_chars[w][i] != recent_chars[len-1-i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic advance_segmenter(in_t b);
        out_t v;
        logic hit;
        int   i;
        int   w;
        case (b.kind)
            KIND_DICT:
            begin
                if (lex_count < N_WORDS && lex_fill < WORD_MAX)
                    lex_chars[lex_count][lex_fill] = b.char_code;
                if (lex_fill <= WORD_MAX)
                    lex_fill++;
                if (b.word_end)
                begin
                    if (lex_fill > WORD_MAX || lex_count >= N_WORDS)
                        lex_dropped = 1'b1;
                    else
                    begin
                        lex_len[lex_count] = lex_fill;
                        lex_count++;
                    end
                    lex_fill = 0;
                end
            end
            KIND_TEXT:
            begin
                for (i = WORD_MAX - 1; i > 0; i--)
                    recent_chars[i] = recent_chars[i-1];
                recent_chars[0] = b.char_code;
                if (text_seen < WORD_MAX)
                    text_seen++;
                hit = 1'b0;
                for (w = 0; w < lex_count; w++)
                    if (word_ends_here(w))
                        hit = 1'b1;
                reachable = {reachable[WORD_MAX-1:0], hit};
            end
            KIND_EOT:
            begin
                v.segmentable   = reachable[0];
                v.words_dropped = lex_dropped;
                pending_verdicts = {pending_verdicts, v};
                restart_text();
            end
            KIND_CLEAR:
            begin
                for (w = 0; w < N_WORDS; w++)
                    lex_len[w] = 0;
                lex_count   = 0;
                lex_fill    = 0;
                lex_dropped = 1'b0;
            end
        endcase
    endtask

    function automatic in_t mk_beat(logic [1:0] k, logic [7:0] c, logic e);
        in_t b;
        b.kind      = k;
        b.char_code = c;
        b.word_end  = e;
        return b;
    endfunction

    task automatic send_beat(in_t b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_segmenter(b);
        beats_sent++;
    endtask

    task automatic send_dict_char(logic [7:0] c, logic last);
        send_beat(mk_beat(KIND_DICT, c, last));
    endtask

    task automatic send_text_char(logic [7:0] c);
        send_beat(mk_beat(KIND_TEXT, c, 1'($urandom)));
    endtask

    task automatic send_eot();
        send_beat(mk_beat(KIND_EOT, 8'($urandom), 1'($urandom)));
    endtask

    task automatic send_clear();
        send_beat(mk_beat(KIND_CLEAR, 8'($urandom), 1'($urandom)));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic pick_glyphs();
        int i;
        glyph_n = $urandom_range(2, 4);
        for (i = 0; i < 4; i++)
            glyphs[i] = 8'($urandom);
    endtask

    function automatic logic [7:0] rand_glyph();
        return glyphs[$urandom_range(0, glyph_n - 1)];
    endfunction

    task automatic load_random_word();
        int r;
        int len;
        int i;
        r = $urandom_range(0, 99);
        if (r < 85)
            len = $urandom_range(1, 4);
        else if (r < 96)
            len = $urandom_range(5, 16);
        else
            len = $urandom_range(17, 20);
        for (i = 0; i < len; i++)
            send_dict_char(rand_glyph(), i == len - 1);
    endtask

    // text made of stored words, optionally with a few chars swapped
    task automatic send_built_text(int nw, bit corrupt);
        int k;
        int w;
        int i;
        logic [7:0] c;
        for (k = 0; k < nw; k++)
        begin
            if (lex_count == 0)
                send_text_char(rand_glyph());
            else
            begin
                w = $urandom_range(0, lex_count - 1);
                for (i = 0; i < lex_len[w]; i++)
                begin
                    c = lex_chars[w][i];
                    if (corrupt && $urandom_range(0, 7) == 0)
                        c = rand_glyph();
                    send_text_char(c);
                end
            end
        end
        send_eot();
    endtask

    task automatic test_directed_basics();
        send_beat(mk_beat(KIND_EOT, 8'hFF, 1'b1));
        send_beat(mk_beat(KIND_DICT, 8'h00, 1'b0));
        send_beat(mk_beat(KIND_DICT, 8'hFF, 1'b1));
        send_beat(mk_beat(KIND_DICT, 8'hFF, 1'b1));
        send_beat(mk_beat(KIND_DICT, 8'hFF, 1'b1));
        send_beat(mk_beat(KIND_TEXT, 8'h00, 1'b1));
        send_beat(mk_beat(KIND_TEXT, 8'hFF, 1'b0));
        send_beat(mk_beat(KIND_TEXT, 8'hFF, 1'b1));
        send_beat(mk_beat(KIND_EOT, 8'h00, 1'b0));
        send_beat(mk_beat(KIND_TEXT, 8'hFF, 1'b0));
        send_beat(mk_beat(KIND_TEXT, 8'h00, 1'b0));
        send_beat(mk_beat(KIND_EOT, 8'h5A, 1'b1));
        // clear abandons the partly loaded word
        send_beat(mk_beat(KIND_DICT, 8'h55, 1'b0));
        send_beat(mk_beat(KIND_CLEAR, 8'hFF, 1'b1));
        send_beat(mk_beat(KIND_DICT, 8'hAA, 1'b1));
        send_beat(mk_beat(KIND_TEXT, 8'hAA, 1'b0));
        send_beat(mk_beat(KIND_EOT, 8'h00, 1'b0));
        send_beat(mk_beat(KIND_TEXT, 8'h55, 1'b0));
        send_beat(mk_beat(KIND_TEXT, 8'hAA, 1'b1));
        send_beat(mk_beat(KIND_EOT, 8'hFF, 1'b0));
        // word added mid-text only counts for later chars
        send_beat(mk_beat(KIND_TEXT, 8'h33, 1'b0));
        send_beat(mk_beat(KIND_DICT, 8'h33, 1'b1));
        send_beat(mk_beat(KIND_TEXT, 8'h33, 1'b0));
        send_beat(mk_beat(KIND_EOT, 8'h33, 1'b1));
    endtask

    task automatic test_dropped_words();
        logic [7:0] longest [WORD_MAX];
        int i;
        send_clear();
        for (i = 0; i < 20; i++)
            send_dict_char(8'($urandom), i == 19);
        send_eot();
        send_clear();
        send_eot();
        for (i = 0; i < WORD_MAX; i++)
        begin
            longest[i] = 8'($urandom);
            send_dict_char(longest[i], i == WORD_MAX - 1);
        end
        for (i = 0; i < WORD_MAX; i++)
            send_text_char(longest[i]);
        send_eot();
        for (i = 1; i < N_WORDS; i++)
            send_dict_char(8'($urandom), 1'b1);
        send_dict_char(longest[0], 1'b0);
        send_dict_char(longest[1], 1'b1);
        send_text_char(longest[0]);
        send_eot();
        send_clear();
    endtask

    task automatic test_backpressure();
        int n;
        hold_left = HOLD_CYCLES;
        n = 0;
        while (n < 4)
        begin
            send_built_text($urandom_range(1, 3), 1'b0);
            n++;
        end
        wait_drained();
        send_built_text($urandom_range(1, 3), 1'b0);
    endtask

    task automatic test_random_traffic(int quota);
        int start;
        int r;
        int n;
        start = beats_sent;
        while (beats_sent - start < quota)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    send_clear();
                    pick_glyphs();
                end
                n = $urandom_range(1, 5);
                repeat (n) load_random_word();
                n = $urandom_range(1, 4);
                repeat (n) send_built_text($urandom_range(0, 5), $urandom_range(0, 3) == 0);
            end
            else if (r < 9)
            begin
                n = $urandom_range(1, 8);
                repeat (n) send_beat(mk_beat(2'($urandom_range(0, 3)), 8'($urandom),
                                             1'($urandom)));
            end
            else
            begin
                // dictionary edits inside a text and inside a word
                send_text_char(rand_glyph());
                send_text_char(rand_glyph());
                load_random_word();
                send_dict_char(rand_glyph(), 1'b0);
                if ($urandom_range(0, 1) == 1)
                    send_clear();
                send_built_text($urandom_range(0, 3), 1'b0);
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            verdicts_seen++;
            if (out_data.segmentable)
                seg_true_seen++;
            if (out_data.words_dropped)
                dropped_seen++;
            if (pending_verdicts.size() == 0)
                report_mismatch("result beat with no verdict pending");
            else
            begin
                verdict_due = pending_verdicts.pop_front();
                if (out_data.segmentable !== verdict_due.segmentable)
                    report_mismatch($sformatf("segmentable got %b want %b",
                                              out_data.segmentable,
                                              verdict_due.segmentable));
                if (out_data.words_dropped !== verdict_due.words_dropped)
                    report_mismatch($sformatf("words_dropped got %b want %b",
                                              out_data.words_dropped,
                                              verdict_due.words_dropped));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("watchdog: no beat accepted for %0d cycles", STUCK_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        hold_left      = 0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        beats_sent     = 0;
        verdicts_seen  = 0;
        seg_true_seen  = 0;
        dropped_seen   = 0;
        mismatch_count = 0;
        stuck_cycles   = 0;
        reset_segmenter();
        pick_glyphs();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_basics();
        test_dropped_words();
        test_random_traffic(330);
        test_backpressure();
        send_idle_pct = 60;
        stall_pct     = 0;
        test_random_traffic(330);
        send_idle_pct = 0;
        stall_pct     = 60;
        test_random_traffic(330);
        send_idle_pct = 31;
        stall_pct     = 31;
        test_random_traffic(330);

        wait_drained();
        repeat (40) @(posedge clk);
        $display("covered %0d beats: directed, dropped words, held results, four idle mixes",
                 beats_sent);
        $display("%0d verdicts checked (%0d segmentable, %0d with dropped words), %0d mismatches",
                 verdicts_seen, seg_true_seen, dropped_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
